// ----- rtl/pfe_pkg.sv -----
// shared constants, codes and payload types of the palette fade engine
`timescale 1ns / 1ps

package pfe_pkg;

    // palette geometry
    localparam int ENTRIES = 64;
    localparam int BANKS   = 2;
    localparam int IDX_W   = 6;
    localparam int BANK_W  = 1;
    localparam int ADDR_W  = BANK_W + IDX_W;
    localparam int DEPTH   = BANKS * ENTRIES;
    localparam int CH_W    = 8;
    localparam int CNT_W   = 5;

    // fade arithmetic
    localparam logic [CH_W-1:0]  STEP_VAL  = 8'd32;
    localparam logic [CH_W-1:0]  WHITE     = 8'd224;
    localparam logic [CNT_W-1:0] LAST_TICK = 5'd21;

    // request queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // request kinds
    localparam logic [2:0] KIND_WCUR  = 3'd0;
    localparam logic [2:0] KIND_WTGT  = 3'd1;
    localparam logic [2:0] KIND_START = 3'd2;
    localparam logic [2:0] KIND_TICK  = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // fade modes
    localparam logic [2:0] FADE_NONE = 3'd0;
    localparam logic [2:0] FADE_IN   = 3'd1;
    localparam logic [2:0] FADE_OUT  = 3'd2;
    localparam logic [2:0] FLASH_IN  = 3'd3;
    localparam logic [2:0] FLASH_OUT = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ENTRY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_BANK = 2'd2;

    typedef struct packed {
        logic [2:0]      kind;
        logic [0:0]      bank;
        logic [5:0]      index;
        logic [7:0]      red_in;
        logic [7:0]      green_in;
        logic [7:0]      blue_in;
        logic [2:0]      fade_kind;
    } pfe_in_t;

    typedef struct packed {
        logic [7:0]      red_out;
        logic [7:0]      green_out;
        logic [7:0]      blue_out;
        logic [0:0]      done_res;
    } pfe_out_t;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } rgb_t;

    // classified operations handed to the back end
    typedef enum logic [2:0] {
        OP_NOP,
        OP_WCUR,
        OP_WTGT,
        OP_START,
        OP_TICK,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        rgb_t              color;
        logic [2:0]        fade;
    } pfe_cmd_t;

endpackage

// ----- rtl/pfe_front.sv -----
// front end: accepts requests and classifies them into back-end operations
`timescale 1ns / 1ps

module pfe_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  pfe_pkg::pfe_in_t in_data,
    input  logic             q_full,
    output logic             push,
    output pfe_pkg::pfe_cmd_t push_cmd
);

    logic addr_ok;
    logic fade_ok;
    logic seen_reg;
    logic seen_next;

    // stall while the queue has no room
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // address and fade kind checks
    assign addr_ok = (int'(in_data.bank) < pfe_pkg::BANKS)
                  && (int'(in_data.index) < pfe_pkg::ENTRIES);
    assign fade_ok = (in_data.fade_kind == pfe_pkg::FADE_IN)
                  || (in_data.fade_kind == pfe_pkg::FADE_OUT)
                  || (in_data.fade_kind == pfe_pkg::FLASH_IN)
                  || (in_data.fade_kind == pfe_pkg::FLASH_OUT);

    // classify the request
    always_comb
    begin
        push_cmd.addr  = {in_data.bank, in_data.index};
        push_cmd.color = '{r: in_data.red_in, g: in_data.green_in, b: in_data.blue_in};
        push_cmd.fade  = in_data.fade_kind;
        unique case (in_data.kind)
            pfe_pkg::KIND_WCUR:  push_cmd.op = addr_ok ? pfe_pkg::OP_WCUR : pfe_pkg::OP_NOP;
            pfe_pkg::KIND_WTGT:  push_cmd.op = addr_ok ? pfe_pkg::OP_WTGT : pfe_pkg::OP_NOP;
            pfe_pkg::KIND_READ:  push_cmd.op = addr_ok ? pfe_pkg::OP_READ : pfe_pkg::OP_NOP;
            pfe_pkg::KIND_START: push_cmd.op = fade_ok ? pfe_pkg::OP_START : pfe_pkg::OP_NOP;
            pfe_pkg::KIND_TICK:  push_cmd.op = pfe_pkg::OP_TICK;
            default:             push_cmd.op = pfe_pkg::OP_NOP;
        endcase
    end

    // remembers that a request has gone through since reset
    assign seen_next = seen_reg || push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    // a request can only be taken when the queue has room
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !in_stall)
        else $error("front pushed into a full queue");
    assert property (@(posedge clk) disable iff (!rst_n) push |=> seen_reg)
        else $error("request tracking lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && in_data.kind == pfe_pkg::KIND_TICK) |-> push_cmd.op == pfe_pkg::OP_TICK)
        else $error("tick request misclassified");

endmodule

// ----- rtl/pfe_queue.sv -----
// short request queue between the front end and the back end
`timescale 1ns / 1ps

module pfe_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pfe_pkg::pfe_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output pfe_pkg::pfe_cmd_t pop_cmd,
    output logic              not_empty
);

    pfe_pkg::pfe_cmd_t               slot_reg [pfe_pkg::QDEPTH];
    logic [pfe_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [pfe_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [pfe_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [pfe_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [pfe_pkg::QCNT_W-1:0]      count_reg;
    logic [pfe_pkg::QCNT_W-1:0]      count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full      = (count_reg == pfe_pkg::QCNT_W'(pfe_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pfe_pkg::QCNT_W'(pfe_pkg::QDEPTH))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && full && !pop) |=> full)
        else $error("queue lost fullness on a refused push");
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg == rd_ptr_reg) |-> (count_reg == '0 || full))
        else $error("queue pointers disagree with count");

endmodule

// ----- rtl/pfe_back.sv -----
// back end: palette memories, fade sweeps, reads and the result register
`timescale 1ns / 1ps

module pfe_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  pfe_pkg::pfe_cmd_t                  q_cmd,
    output logic                               q_pop,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pfe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pfe_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output pfe_pkg::pfe_out_t                  out_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FILL,
        ST_SWEEP,
        ST_FLUSH
    } state_t;

    // next channel value for one entry on one tick
    function automatic pfe_pkg::rgb_t step_entry(input logic [2:0] mode,
                                                 input pfe_pkg::rgb_t c,
                                                 input pfe_pkg::rgb_t t);
        pfe_pkg::rgb_t n;
        n = c;
        unique case (mode)
            pfe_pkg::FADE_IN:
            begin
                if (t.b > c.b)      n.b = c.b + pfe_pkg::STEP_VAL;
                else if (t.g > c.g) n.g = c.g + pfe_pkg::STEP_VAL;
                else if (t.r > c.r) n.r = c.r + pfe_pkg::STEP_VAL;
            end
            pfe_pkg::FADE_OUT:
            begin
                if (c.r != '0)      n.r = c.r - pfe_pkg::STEP_VAL;
                else if (c.g != '0) n.g = c.g - pfe_pkg::STEP_VAL;
                else if (c.b != '0) n.b = c.b - pfe_pkg::STEP_VAL;
            end
            pfe_pkg::FLASH_IN:
            begin
                if (t.b < c.b)      n.b = c.b - pfe_pkg::STEP_VAL;
                else if (t.g < c.g) n.g = c.g - pfe_pkg::STEP_VAL;
                else if (t.r < c.r) n.r = c.r - pfe_pkg::STEP_VAL;
            end
            pfe_pkg::FLASH_OUT:
            begin
                if (c.r != pfe_pkg::WHITE)      n.r = c.r + pfe_pkg::STEP_VAL;
                else if (c.g != pfe_pkg::WHITE) n.g = c.g + pfe_pkg::STEP_VAL;
                else if (c.b != pfe_pkg::WHITE) n.b = c.b + pfe_pkg::STEP_VAL;
            end
            default: n = c;
        endcase
        return n;
    endfunction

    // palette memories and their valid bits
    pfe_pkg::rgb_t                   cur_pal_reg [pfe_pkg::DEPTH];
    pfe_pkg::rgb_t                   tgt_pal_reg [pfe_pkg::DEPTH];
    logic                            cur_valid_reg [pfe_pkg::DEPTH];
    logic                            tgt_valid_reg [pfe_pkg::DEPTH];
    pfe_pkg::rgb_t                   cur_rd_reg;
    pfe_pkg::rgb_t                   tgt_rd_reg;
    logic                            cur_rdv_reg;
    logic                            tgt_rdv_reg;
    pfe_pkg::rgb_t                   cur_eff;
    pfe_pkg::rgb_t                   tgt_eff;

    logic                            cur_we;
    logic [pfe_pkg::ADDR_W-1:0]      cur_wa;
    pfe_pkg::rgb_t                   cur_wd;
    logic                            tgt_we;
    logic [pfe_pkg::ADDR_W-1:0]      tgt_wa;
    pfe_pkg::rgb_t                   tgt_wd;
    logic [pfe_pkg::ADDR_W-1:0]      rd_addr;

    // configuration registers
    logic [pfe_pkg::IDX_W-1:0]       first_entry_reg;
    logic [pfe_pkg::IDX_W-1:0]       last_offset_reg;
    logic                            single_bank_reg;

    // fade state and sequencer
    state_t                          state_reg;
    state_t                          state_next;
    logic [2:0]                      mode_reg;
    logic [2:0]                      mode_next;
    logic [pfe_pkg::CNT_W-1:0]       step_count_reg;
    logic [pfe_pkg::CNT_W-1:0]       step_count_next;
    logic [pfe_pkg::CNT_W-1:0]       count_inc;
    logic [pfe_pkg::IDX_W-1:0]       range_start_reg;
    logic [pfe_pkg::IDX_W-1:0]       range_start_next;
    logic [pfe_pkg::IDX_W-1:0]       range_extra_reg;
    logic [pfe_pkg::IDX_W-1:0]       range_extra_next;
    logic [pfe_pkg::IDX_W:0]         end_sum;
    logic [pfe_pkg::IDX_W-1:0]       range_end;
    logic [pfe_pkg::IDX_W-1:0]       ptr_reg;
    logic [pfe_pkg::IDX_W-1:0]       ptr_next;
    logic [pfe_pkg::BANK_W-1:0]      bank_reg;
    logic [pfe_pkg::BANK_W-1:0]      bank_next;
    logic                            two_banks_reg;
    logic                            two_banks_next;
    logic [pfe_pkg::CH_W-1:0]        fill_reg;
    logic [pfe_pkg::CH_W-1:0]        fill_next;
    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic [pfe_pkg::ADDR_W-1:0]      s1_addr_reg;
    logic [pfe_pkg::ADDR_W-1:0]      s1_addr_next;

    // result register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    pfe_pkg::pfe_out_t               out_data_reg;
    pfe_pkg::pfe_out_t               out_data_next;
    logic                            out_free;
    logic                            out_load;
    pfe_pkg::pfe_out_t               out_load_data;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // entries never written read as zero
    assign cur_eff = cur_rdv_reg ? cur_rd_reg : '0;
    assign tgt_eff = tgt_rdv_reg ? tgt_rd_reg : '0;

    // last entry of the fade range, clamped to the palette
    assign end_sum   = {1'b0, range_start_reg} + {1'b0, range_extra_reg};
    assign range_end = (end_sum > (pfe_pkg::IDX_W + 1)'(pfe_pkg::ENTRIES - 1))
                     ? pfe_pkg::IDX_W'(pfe_pkg::ENTRIES - 1)
                     : end_sum[pfe_pkg::IDX_W-1:0];
    assign count_inc = step_count_reg + 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_entry_reg <= '0;
            last_offset_reg <= '1;
            single_bank_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pfe_pkg::CFG_FIRST_ENTRY: first_entry_reg <= cfg_data[pfe_pkg::IDX_W-1:0];
                pfe_pkg::CFG_LAST_OFFSET: last_offset_reg <= cfg_data[pfe_pkg::IDX_W-1:0];
                pfe_pkg::CFG_SINGLE_BANK: single_bank_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        step_count_next  = step_count_reg;
        range_start_next = range_start_reg;
        range_extra_next = range_extra_reg;
        ptr_next         = ptr_reg;
        bank_next        = bank_reg;
        two_banks_next   = two_banks_reg;
        fill_next        = fill_reg;
        s1_valid_next    = 1'b0;
        s1_addr_next     = s1_addr_reg;
        q_pop            = 1'b0;
        out_load         = 1'b0;
        out_load_data    = '0;
        cur_we           = 1'b0;
        cur_wa           = q_cmd.addr;
        cur_wd           = q_cmd.color;
        tgt_we           = 1'b0;
        tgt_wa           = q_cmd.addr;
        tgt_wd           = q_cmd.color;
        rd_addr          = {bank_reg, ptr_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.op)
                        pfe_pkg::OP_WCUR:
                        begin
                            cur_we   = 1'b1;
                            out_load = 1'b1;
                        end
                        pfe_pkg::OP_WTGT:
                        begin
                            tgt_we   = 1'b1;
                            out_load = 1'b1;
                        end
                        pfe_pkg::OP_READ:
                        begin
                            rd_addr    = q_cmd.addr;
                            state_next = ST_READ;
                        end
                        pfe_pkg::OP_START:
                        begin
                            out_load        = 1'b1;
                            step_count_next = '0;
                            mode_next       = q_cmd.fade;
                            if (q_cmd.fade == pfe_pkg::FADE_IN)
                            begin
                                range_start_next = first_entry_reg;
                                range_extra_next = last_offset_reg;
                                ptr_next         = first_entry_reg;
                                fill_next        = '0;
                                state_next       = ST_FILL;
                            end
                            else
                            begin
                                range_start_next = '0;
                                range_extra_next = '1;
                                ptr_next         = '0;
                                fill_next        = pfe_pkg::WHITE;
                                if (q_cmd.fade == pfe_pkg::FLASH_IN)
                                begin
                                    state_next = ST_FILL;
                                end
                            end
                        end
                        pfe_pkg::OP_TICK:
                        begin
                            if (mode_reg != pfe_pkg::FADE_NONE)
                            begin
                                bank_next      = '0;
                                ptr_next       = range_start_reg;
                                two_banks_next = (pfe_pkg::BANKS > 1)
                                              && (mode_reg == pfe_pkg::FADE_OUT
                                               || mode_reg == pfe_pkg::FLASH_OUT
                                               || !single_bank_reg);
                                state_next     = ST_SWEEP;
                            end
                            else
                            begin
                                out_load               = 1'b1;
                                out_load_data.done_res = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                out_load                = 1'b1;
                out_load_data.red_out   = cur_eff.r;
                out_load_data.green_out = cur_eff.g;
                out_load_data.blue_out  = cur_eff.b;
                state_next              = ST_IDLE;
            end
            ST_FILL:
            begin
                cur_we = 1'b1;
                cur_wa = {pfe_pkg::BANK_W'(0), ptr_reg};
                cur_wd = '{r: fill_reg, g: fill_reg, b: fill_reg};
                if (ptr_reg == range_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_SWEEP:
            begin
                s1_valid_next = 1'b1;
                s1_addr_next  = {bank_reg, ptr_reg};
                if (ptr_reg == range_end)
                begin
                    if (bank_reg == '0 && two_banks_reg)
                    begin
                        bank_next = bank_reg + 1'b1;
                        ptr_next  = range_start_reg;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_FLUSH:
            begin
                out_load = 1'b1;
                if (count_inc > pfe_pkg::LAST_TICK)
                begin
                    step_count_next        = '0;
                    out_load_data.done_res = 1'b1;
                end
                else
                begin
                    step_count_next = count_inc;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // write back the stepped entry in the cycle after its read
        if (s1_valid_reg)
        begin
            cur_we = 1'b1;
            cur_wa = s1_addr_reg;
            cur_wd = step_entry(mode_reg, cur_eff, tgt_eff);
        end

        // result register
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = out_load_data;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mode_reg        <= pfe_pkg::FADE_NONE;
            step_count_reg  <= '0;
            range_start_reg <= '0;
            range_extra_reg <= '1;
            ptr_reg         <= '0;
            bank_reg        <= '0;
            two_banks_reg   <= 1'b0;
            fill_reg        <= '0;
            s1_valid_reg    <= 1'b0;
            s1_addr_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            step_count_reg  <= step_count_next;
            range_start_reg <= range_start_next;
            range_extra_reg <= range_extra_next;
            ptr_reg         <= ptr_next;
            bank_reg        <= bank_next;
            two_banks_reg   <= two_banks_next;
            fill_reg        <= fill_next;
            s1_valid_reg    <= s1_valid_next;
            s1_addr_reg     <= s1_addr_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pfe_pkg::DEPTH; i++)
            begin
                cur_valid_reg[i] <= 1'b0;
                tgt_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cur_we)
            begin
                cur_valid_reg[cur_wa] <= 1'b1;
            end
            if (tgt_we)
            begin
                tgt_valid_reg[tgt_wa] <= 1'b1;
            end
        end
    end

    // current palette memory
    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_pal_reg[cur_wa] <= cur_wd;
        end
        cur_rd_reg  <= cur_pal_reg[rd_addr];
        cur_rdv_reg <= cur_valid_reg[rd_addr];
    end

    // target palette memory
    always_ff @(posedge clk)
    begin
        if (tgt_we)
        begin
            tgt_pal_reg[tgt_wa] <= tgt_wd;
        end
        tgt_rd_reg  <= tgt_pal_reg[rd_addr];
        tgt_rdv_reg <= tgt_valid_reg[rd_addr];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (state_reg == ST_SWEEP || state_reg == ST_FLUSH))
        else $error("writeback outside a sweep");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        step_count_reg <= pfe_pkg::LAST_TICK)
        else $error("step count past last tick");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> out_valid_reg)
        else $error("read produced no result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && bank_reg != '0) |-> two_banks_reg)
        else $error("second bank swept when it should be skipped");

endmodule

// ----- rtl/palette_fade_engine_unit.sv -----
// top level of the palette fade engine
`timescale 1ns / 1ps

// Palette fade engine: current and target RGB palettes of 64 entries in each
// of two banks, with write, read, fade start and frame tick requests. A
// four-deep queue sits between the request port and the execution back end,
// and each request gives exactly one result. Writes, unknown requests, fade
// starts without a fill and ticks with no fade active finish in the idle
// state of the back end; a read also passes through a read state. A fade-in
// or flash-in start then fills each entry of its range in bank 0 in turn.
// An active tick steps each entry of the range in each bank it sweeps and
// then gives its result from a flush state; the one read and one write port
// of the current palette memory pace that sweep. Reset needs no clearing
// pass: entries never written read as zero through per-entry valid bits.

module palette_fade_engine_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  pfe_pkg::pfe_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output pfe_pkg::pfe_out_t                  out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pfe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pfe_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic              push;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    pfe_pkg::pfe_cmd_t push_cmd;
    pfe_pkg::pfe_cmd_t q_cmd;

    // request classification
    pfe_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // request queue
    pfe_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_cmd   (q_cmd),
        .not_empty (q_valid)
    );

    // execution and results
    pfe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
